FILE: rtl/query_dsl_tokenizer_core_defines.svh
// assertion macros shared by the tokenizer rtl
`ifndef QUERY_DSL_TOKENIZER_CORE_DEFINES_SVH
`define QUERY_DSL_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTH
// checked while out of reset
`define QDT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qdt assertion failed");
// checked on every edge, reset included
`define QDT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qdt assertion failed");
`else
`define QDT_ASSERT(lbl, clk, rstn, prop)
`define QDT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/qdt_pkg.sv
package qdt_pkg;

    // string length limit and offset width
    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);

    // token kinds
    localparam logic [3:0] K_EOF      = 4'd0;
    localparam logic [3:0] K_IDENT    = 4'd1;
    localparam logic [3:0] K_IN       = 4'd2;
    localparam logic [3:0] K_OUT      = 4'd3;
    localparam logic [3:0] K_INOUT    = 4'd4;
    localparam logic [3:0] K_COMMA    = 4'd5;
    localparam logic [3:0] K_NOT      = 4'd6;
    localparam logic [3:0] K_OPTIONAL = 4'd7;
    localparam logic [3:0] K_LPAREN   = 4'd8;
    localparam logic [3:0] K_RPAREN   = 4'd9;
    localparam logic [3:0] K_WILD     = 4'd10;
    localparam logic [3:0] K_WILD_ONE = 4'd11;
    localparam logic [3:0] K_OR       = 4'd12;
    localparam logic [3:0] K_ERROR    = 4'd13;

    // lexer modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_IDENT   = 2'd1;
    localparam logic [1:0] MODE_BAR     = 2'd2;
    localparam logic [1:0] MODE_BRACKET = 2'd3;

    // bracket contents prefix match
    localparam logic [3:0] BM_EMPTY = 4'd0;
    localparam logic [3:0] BM_I     = 4'd1;
    localparam logic [3:0] BM_IN    = 4'd2;
    localparam logic [3:0] BM_INO   = 4'd3;
    localparam logic [3:0] BM_INOU  = 4'd4;
    localparam logic [3:0] BM_INOUT = 4'd5;
    localparam logic [3:0] BM_O     = 4'd6;
    localparam logic [3:0] BM_OU    = 4'd7;
    localparam logic [3:0] BM_OUT   = 4'd8;
    localparam logic [3:0] BM_FAIL  = 4'd9;

    // one result word
    typedef struct packed {
        logic [3:0]  kind;
        logic [11:0] start;
        logic [11:0] length;
        logic        last;
    } tok_t;

    // results caused by one input byte, at most two
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } lex_res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || (c inside {["0":"9"]}) || (c == "_");
    endfunction

    function automatic logic [3:0] match_step(input logic [3:0] m, input logic [7:0] c);
        logic [3:0] r;
        r = BM_FAIL;
        case (m)
            BM_EMPTY: r = (c == "i") ? BM_I : ((c == "o") ? BM_O : BM_FAIL);
            BM_I:     r = (c == "n") ? BM_IN : BM_FAIL;
            BM_IN:    r = (c == "o") ? BM_INO : BM_FAIL;
            BM_INO:   r = (c == "u") ? BM_INOU : BM_FAIL;
            BM_INOU:  r = (c == "t") ? BM_INOUT : BM_FAIL;
            BM_O:     r = (c == "u") ? BM_OU : BM_FAIL;
            BM_OU:    r = (c == "t") ? BM_OUT : BM_FAIL;
            default:  r = BM_FAIL;
        endcase
        return r;
    endfunction

    // single symbol kind, error for anything else
    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        k = K_ERROR;
        case (c)
            ",":     k = K_COMMA;
            "!":     k = K_NOT;
            "?":     k = K_OPTIONAL;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "*":     k = K_WILD;
            "_":     k = K_WILD_ONE;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/query_dsl_tokenizer_core.sv
// query string tokenizer
// s_ channel: one string byte per word in s_tdata[7:0]; byte 0 ends the string,
// flushes any pending token, emits eof and restarts offsets at 0.
// m_ channel: one token per word; kind, start offset and length in m_tdata,
// m_tlast marks the final token caused by one input byte.
// a byte may cause zero, one or two tokens; bytes inside an identifier or a
// bracket cause none until the token is complete.
// ordering: the tokens that a byte completes are registered in the result
// queue and leave m_ from it in order, the first before the second.
// throughput: one byte per cycle while s_tready is high; the lexer state update is the only loop.
// a four-word result queue sits between lexer and m_; s_tready is high while
// it has room for two words, so a stalled receiver holds off s_ once three
// or more words wait, and no word is lost.
// reset (aresetn low, synchronous) empties the queue, sets offset and
// pending start to 0, and returns the lexer to idle.
module query_dsl_tokenizer_core import qdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // token_kind[3:0], token_start[15:4], token_length[27:16], zero
    output logic        m_tlast    // last_of_run
);

    logic     accept;
    lex_res_t res;

    assign accept = s_tvalid && s_tready;

    // byte lexer with its state
    qdt_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_tdata),
        .res     (res)
    );

    // result queue and output side
    qdt_out_fifo u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_res (res),
        .room     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/qdt_lexer.sv
`include "query_dsl_tokenizer_core_defines.svh"

module qdt_lexer import qdt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] ch,
    output lex_res_t   res
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [1:0]       mode_reg, mode_next;
    logic [3:0]       match_reg, match_next;

    tok_t pend_tok, main_tok;
    logic pend_vld, main_vld;
    logic cont, adv, eof;

    // next state and results for the byte at the input
    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        match_next = match_reg;
        pend_tok   = '0;
        main_tok   = '0;
        pend_vld   = 1'b0;
        main_vld   = 1'b0;
        cont       = 1'b1;
        adv        = 1'b0;
        eof        = 1'b0;

        // finish or extend the pending token
        case (mode_reg)
            MODE_IDENT: begin
                if (is_ident_char(ch)) begin
                    adv  = 1'b1;
                    cont = 1'b0;
                end else begin
                    pend_vld       = 1'b1;
                    pend_tok.kind  = K_IDENT;
                    pend_tok.start = 12'(start_reg);
                    pend_tok.length = (pos_reg >= start_reg) ?
                                      12'(pos_reg - start_reg) : 12'd0;
                    mode_next      = MODE_IDLE;
                end
            end
            MODE_BAR: begin
                mode_next      = MODE_IDLE;
                pend_vld       = 1'b1;
                pend_tok.start = 12'(start_reg);
                if (ch == "|") begin
                    pend_tok.kind   = K_OR;
                    pend_tok.length = 12'd2;
                    adv             = 1'b1;
                    cont            = 1'b0;
                end else begin
                    pend_tok.kind   = K_ERROR;
                end
            end
            MODE_BRACKET: begin
                if (ch != "]" && ch != 8'd0) begin
                    match_next = match_step(match_reg, ch);
                    adv        = 1'b1;
                    cont       = 1'b0;
                end else begin
                    pend_vld       = 1'b1;
                    pend_tok.start = 12'(start_reg);
                    case (match_reg)
                        BM_IN: begin
                            pend_tok.kind   = K_IN;
                            pend_tok.length = 12'd2;
                        end
                        BM_OUT: begin
                            pend_tok.kind   = K_OUT;
                            pend_tok.length = 12'd3;
                        end
                        BM_INOUT: begin
                            pend_tok.kind   = K_INOUT;
                            pend_tok.length = 12'd5;
                        end
                        default: pend_tok.kind = K_ERROR;
                    endcase
                    mode_next  = MODE_IDLE;
                    match_next = BM_EMPTY;
                    if (ch == "]") begin
                        adv  = 1'b1;
                        cont = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // lex the byte from idle
        if (cont) begin
            if (ch == 8'd0) begin
                eof            = 1'b1;
                main_vld       = 1'b1;
                main_tok.kind  = K_EOF;
                main_tok.start = 12'(pos_reg);
                start_next     = '0;
                match_next     = BM_EMPTY;
                mode_next      = MODE_IDLE;
            end else if (is_space(ch)) begin
                adv = 1'b1;
            end else if (ch == "|") begin
                mode_next  = MODE_BAR;
                start_next = pos_reg;
                adv        = 1'b1;
            end else if (ch == "[") begin
                mode_next  = MODE_BRACKET;
                start_next = pos_reg;
                match_next = BM_EMPTY;
                adv        = 1'b1;
            end else if (is_alpha(ch)) begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                adv        = 1'b1;
            end else begin
                main_vld        = 1'b1;
                main_tok.kind   = symbol_kind(ch);
                main_tok.start  = 12'(pos_reg);
                main_tok.length = (symbol_kind(ch) == K_ERROR) ? 12'd0 : 12'd1;
                adv             = 1'b1;
            end
        end

        // saturating offset count, cleared by the terminator
        pos_next = pos_reg;
        if (eof) begin
            pos_next = '0;
        end else if (adv && pos_reg != POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // pack results, marking the final one of this byte
    always_comb begin
        res = '0;
        if (pend_vld) begin
            res.tok0  = pend_tok;
            res.tok1  = main_tok;
            res.count = main_vld ? 2'd2 : 2'd1;
            if (main_vld) begin
                res.tok1.last = 1'b1;
            end else begin
                res.tok0.last = 1'b1;
            end
        end else if (main_vld) begin
            res.tok0      = main_tok;
            res.tok0.last = 1'b1;
            res.count     = 2'd1;
        end
    end

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            mode_reg  <= MODE_IDLE;
            match_reg <= BM_EMPTY;
        end else if (accept) begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            mode_reg  <= mode_next;
            match_reg <= match_next;
        end
    end

    `QDT_ASSERT(a_match_idle, aclk, aresetn, (mode_reg != MODE_BRACKET) |-> (match_reg == BM_EMPTY))
    `QDT_ASSERT(a_start_le_pos, aclk, aresetn, (mode_reg != MODE_IDLE) |-> (start_reg <= pos_reg))
    `QDT_ASSERT(a_eof_restart, aclk, aresetn, (accept && ch == 8'd0) |=> (pos_reg == '0))

endmodule

FILE: rtl/qdt_out_fifo.sv
`include "query_dsl_tokenizer_core_defines.svh"

module qdt_out_fifo import qdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  lex_res_t    push_res,
    output logic        room,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // token_kind[3:0], token_start[15:4], token_length[27:16], zero
    output logic        m_tlast    // last_of_run
);

    localparam int DEPTH = 4;

    tok_t       slot_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_cnt;
    logic       pop;
    tok_t       head;

    assign push_cnt = push ? push_res.count : 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign room     = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);
    assign head     = slot_reg[rd_ptr_reg];
    assign m_tdata  = {4'd0, head.length, head.start, head.kind};
    assign m_tlast  = head.last;

    // pointer and fill updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, up to two words written per cycle
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push_res.tok0;
        end
        if (push_cnt == 2'd2) begin
            slot_reg[wr_ptr_reg + 2'd1] <= push_res.tok1;
        end
    end

    `QDT_ASSERT_ALWAYS(a_fill_bound, aclk, !aresetn || (count_reg <= 3'(DEPTH)))
    `QDT_ASSERT(a_no_overflow, aclk, aresetn, push |-> ((count_reg + 3'(push_res.count)) <= 3'(DEPTH)))
    `QDT_ASSERT(a_pop_only, aclk, aresetn, (pop && push_cnt == 2'd0) |=> (count_reg == $past(count_reg) - 3'd1))

endmodule
